/* rtl/qbpn_pkg.sv */
package qbpn_pkg;

  localparam int BLOCK_DEPTH = 64;
  localparam int SAMPLE_W    = 16;
  localparam int PEAK_W      = 15;

  localparam logic [PEAK_W-1:0]   HALF_SCALE  = 15'd16383;
  localparam logic [PEAK_W-1:0]   Q15_MAX_MAG = 15'd32767;
  localparam logic [SAMPLE_W-1:0] Q15_MIN     = 16'h8000;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // input item accepted: store and update peak
    logic rd;     // issue store read at emit index
    logic cap;    // move read data into output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic blk_end;   // the item on the input closes the block
    logic rd_last;   // emit index points at the final stored sample
    logic out_free;  // output register can take a new item this cycle
  } status_t;

  // Saturated magnitude of a Q15 sample
  function automatic logic [PEAK_W-1:0] magnitude(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] neg;
    neg = (~v) + 16'd1;
    if (v == Q15_MIN) begin
      magnitude = Q15_MAX_MAG;
    end else if (v[SAMPLE_W-1]) begin
      magnitude = neg[PEAK_W-1:0];
    end else begin
      magnitude = v[PEAK_W-1:0];
    end
  endfunction

endpackage

/* rtl/qbpn_ram.sv */
module qbpn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/qbpn_ctrl.sv */
module qbpn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  qbpn_pkg::status_t status,
  output qbpn_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CAP  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    in_ready   = (state == ST_LOAD);
    cmd        = '0;
    state_next = state;
    case (state)
      ST_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && status.blk_end) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_CAP;
      end
      ST_CAP: begin
        // hold read data until the output register frees up
        if (status.out_free) begin
          cmd.cap    = 1'b1;
          state_next = status.rd_last ? ST_LOAD : ST_RD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/qbpn_dp.sv */
module qbpn_dp #(
  parameter int BLOCK_DEPTH = qbpn_pkg::BLOCK_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  qbpn_pkg::cmd_t                  cmd,
  output qbpn_pkg::status_t               status,
  input  logic [qbpn_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic                            block_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [qbpn_pkg::SAMPLE_W-1:0]   sample_out,
  output logic [qbpn_pkg::PEAK_W-1:0]     peak_magnitude,
  output logic                            shift_amount,
  output logic                            last_out
);

  localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int CW = $clog2(BLOCK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BLOCK_DEPTH);

  logic [CW-1:0]                  fill;
  logic [CW-1:0]                  fill_inc;
  logic [CW-1:0]                  rd_inc;
  logic [AW-1:0]                  rd_idx;
  logic [qbpn_pkg::PEAK_W-1:0]    peak;
  logic [qbpn_pkg::PEAK_W-1:0]    mag;
  logic [qbpn_pkg::SAMPLE_W-1:0]  rdata;
  logic                           shift;

  assign fill_inc = fill + CW'(1);
  assign rd_inc   = CW'(rd_idx) + CW'(1);
  assign mag      = qbpn_pkg::magnitude(sample_in);
  assign shift    = (peak > qbpn_pkg::HALF_SCALE);

  assign status.blk_end  = block_end || (fill_inc == DEPTH_C);
  assign status.rd_last  = (rd_inc == fill);
  assign status.out_free = !out_valid || out_ready;

  qbpn_ram #(
    .WIDTH (qbpn_pkg::SAMPLE_W),
    .DEPTH (BLOCK_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (fill[AW-1:0]),
    .wdata (sample_in),
    .re    (cmd.rd),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      peak      <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        fill <= fill_inc;
        if (mag > peak) begin
          peak <= mag;
        end
      end
      if (cmd.cap) begin
        out_valid <= 1'b1;
        if (status.rd_last) begin
          rd_idx <= '0;
          fill   <= '0;
          peak   <= '0;
        end else begin
          rd_idx <= rd_idx + AW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      sample_out     <= shift ? {rdata[qbpn_pkg::SAMPLE_W-1], rdata[qbpn_pkg::SAMPLE_W-1:1]}
                              : rdata;
      peak_magnitude <= peak;
      shift_amount   <= shift;
      last_out       <= status.rd_last;
    end
  end

endmodule

/* rtl/q15_block_peak_normalize.sv */
// Block floating-point normalizer for Q15 samples. Samples stream in on the
// slave side, one per item, and are written to an internal store while a
// running peak magnitude is tracked (-32768 counts as 32767). An item with
// tlast set, or the item that fills the store to BLOCK_DEPTH samples, closes
// the block. If the peak exceeds 16383 every sample is then shifted right
// arithmetically by one, otherwise passed unchanged, and the samples leave in
// arrival order, each carrying the peak and the shift, with tlast on the final
// one. Each item is emitted by a store read, then a capture into the output
// register once that is free; the input is not ready while a block is being
// emitted.
module q15_block_peak_normalize #(
  parameter int BLOCK_DEPTH = qbpn_pkg::BLOCK_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
  input  logic        s_axis_tlast,   // block_end
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] sample_out, [30:16] peak_magnitude,
                                      // [31] shift_amount
  output logic        m_axis_tlast    // last_out
);

  qbpn_pkg::cmd_t    cmd;
  qbpn_pkg::status_t status;

  logic [qbpn_pkg::SAMPLE_W-1:0] sample_out;
  logic [qbpn_pkg::PEAK_W-1:0]   peak_magnitude;
  logic                          shift_amount;

  // sequence loading and emitting
  qbpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // store, peak tracking, shift and output register
  qbpn_dp #(
    .BLOCK_DEPTH (BLOCK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sample_in      (s_axis_tdata),
    .block_end      (s_axis_tlast),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .sample_out     (sample_out),
    .peak_magnitude (peak_magnitude),
    .shift_amount   (shift_amount),
    .last_out       (m_axis_tlast)
  );

  assign m_axis_tdata = {shift_amount, peak_magnitude, sample_out};

endmodule

/* sim/q15_block_peak_normalize_test.sv */
module q15_block_peak_normalize_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = qbpn_pkg::BLOCK_DEPTH;
  localparam int HOLD_CYCLES  = 400;   // long output back-pressure stretch
  localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES  = 250;   // covers emitting a full block

  // How the sample values of a generated block are spread
  typedef enum int {
    SPREAD_FULL,  // any 16-bit pattern
    SPREAD_HALF,  // magnitudes at or below half scale, so no shift
    SPREAD_EDGE   // only corner values around zero, full and half scale
  } spread_t;

  typedef struct {
    logic [15:0] sample;
    logic        close;
  } sample_item_t;

  typedef struct {
    logic [15:0] sample;
    logic [14:0] peak;
    logic        shift;
    logic        last;
  } norm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [15:0] sample_in
  logic        s_axis_tlast  = 1'b0; // block_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [15:0] sample_out, [30:16] peak_magnitude,
                                     // [31] shift_amount
  logic        m_axis_tlast;         // last_out

  q15_block_peak_normalize uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Items waiting to be offered, and normalized samples waiting to come out
  sample_item_t pending_samples[$];
  norm_result_t normalized_due[$];

  // Predictor state: the open block and its running peak
  logic [15:0]  open_block[$];
  logic [14:0]  open_peak = '0;

  // Idle percentages per side; changed by the sequencer between phases
  int unsigned  send_idle = 24;
  int unsigned  recv_idle = 83;
  logic         hold_armed = 1'b0;

  int           items_queued   = 0;
  int           items_taken    = 0;
  int           blocks_closed  = 0;
  int           full_closes    = 0;
  int           results_seen   = 0;
  int           errors         = 0;

  // Receiver-side back-pressure bookkeeping, owned by the monitor process
  int           hold_left  = 0;
  logic         hold_taken = 1'b0;

  // Store one accepted sample in the open block and, when the block closes
  // (marked last, or store full), queue every sample normalized by the peak.
  task automatic predict_normalized(input logic [15:0] v, input logic close);
    logic [15:0]  neg;
    logic [14:0]  mag;
    logic         sh;
    norm_result_t r;
    neg = -v;
    // -32768 has no positive twin: saturate its magnitude
    if (v == qbpn_pkg::Q15_MIN) mag = qbpn_pkg::Q15_MAX_MAG;
    else if (v[15])             mag = neg[14:0];
    else                        mag = v[14:0];
    open_block.push_back(v);
    if (mag > open_peak) open_peak = mag;
    if (close || open_block.size() == DEPTH) begin
      // Peak of a Q15 sample needs at most one shift to reach half scale
      sh = (open_peak > qbpn_pkg::HALF_SCALE);
      blocks_closed++;
      if (!close) full_closes++;
      foreach (open_block[k]) begin
        r.sample = $signed(open_block[k]) >>> sh;
        r.peak   = open_peak;
        r.shift  = sh;
        r.last   = (k == open_block.size() - 1);
        normalized_due.push_back(r);
      end
      open_block.delete();
      open_peak = '0;
    end
  endtask

  task automatic push_sample(input logic [15:0] v, input logic close);
    sample_item_t it;
    it.sample = v;
    it.close  = close;
    pending_samples.push_back(it);
    items_queued++;
  endtask

  // Queue one block of n samples; close marks the final one as last.
  task automatic queue_block(input int n, input spread_t spread, input logic close);
    logic [15:0] corners[9];
    logic [15:0] v;
    corners = '{16'h8000, 16'h7FFF, 16'h4000, 16'h3FFF, 16'hC000,
                16'hC001, 16'h0000, 16'hFFFF, 16'h0001};
    for (int i = 0; i < n; i++) begin
      case (spread)
        SPREAD_FULL: v = 16'($urandom);
        SPREAD_HALF: v = 16'(int'($urandom_range(32766)) - 16383);
        default:     v = corners[$urandom_range(8)];
      endcase
      push_sample(v, (i == n - 1) ? close : 1'b0);
    end
  endtask

  // Queue closed blocks of random small sizes until about n samples are queued.
  task automatic queue_random_blocks(input int n);
    int left;
    int len;
    left = n;
    while (left > 0) begin
      len = $urandom_range(12, 1);
      queue_block(len, spread_t'($urandom_range(2)), 1'b1);
      left -= len;
    end
  endtask

  // Hold until every queued sample is taken and every result has come out.
  task automatic drain;
    while (items_taken != items_queued || normalized_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Driver: offer the next pending item, hold it until accepted, and feed
  // every accepted item to the predictor. Each output gets one assignment.
  always @(posedge clk) begin : drive_samples
    logic         nv;
    logic [15:0]  nd;
    logic         nl;
    sample_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      nv = s_axis_tvalid;
      nd = s_axis_tdata;
      nl = s_axis_tlast;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_normalized(s_axis_tdata, s_axis_tlast);
        items_taken++;
        nv = 1'b0;
      end
      // Advance to the next item unless this cycle is picked as a gap
      if (!nv && pending_samples.size() != 0 && $urandom_range(99) >= send_idle) begin
        it = pending_samples.pop_front();
        nv = 1'b1;
        nd = it.sample;
        nl = it.close;
      end
      s_axis_tvalid <= nv;
      s_axis_tdata  <= nd;
      s_axis_tlast  <= nl;
    end
  end

  // Monitor: compare each accepted output item with the oldest expectation
  // and drive tready, including one long hold-off once it is armed.
  always @(posedge clk) begin : watch_results
    norm_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (normalized_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected output item, expected none, actual 0x%0h last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = normalized_due.pop_front();
          check_field("sample_out",     want.sample, m_axis_tdata[15:0]);
          check_field("peak_magnitude", want.peak,   m_axis_tdata[30:16]);
          check_field("shift_amount",   want.shift,  m_axis_tdata[31]);
          check_field("last_out",       want.last,   m_axis_tlast);
        end
      end
      if (hold_armed && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog: end the run if no item moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no item accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Sequencer: reset, then directed blocks, then three random phases.
  initial begin : sequencer
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-sample blocks at full scale, the saturating minimum,
    // a block right at half scale (no shift), just above it, bit toggles.
    push_sample(16'h7FFF, 1'b1);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h3FFF, 1'b0);
    push_sample(16'hC001, 1'b0);
    push_sample(16'h0000, 1'b1);
    push_sample(16'h4000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0001, 1'b1);
    push_sample(16'hC000, 1'b1);
    push_sample(16'h5555, 1'b0);
    push_sample(16'hAAAA, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0000, 1'b1);
    push_sample(16'h0000, 1'b1);
    push_sample(16'hBFFF, 1'b0);
    push_sample(16'h7FFE, 1'b1);

    // Phase one: sender mostly busy, receiver mostly stalled
    queue_random_blocks(12);
    drain();

    // Phase two: swap the idle rates
    send_idle <= 83;
    recv_idle <= 24;
    queue_random_blocks(12);
    drain();

    // Phase three: no idling; a store-filling block under a long output
    // hold-off, so the block fills and stalls its input
    send_idle  <= 0;
    recv_idle  <= 0;
    hold_armed <= 1'b1;
    queue_block(DEPTH, SPREAD_FULL, 1'(($urandom_range(1))));
    queue_random_blocks(6);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d input items in %0d blocks (%0d ended by a full store), %0d outputs.",
             items_taken, blocks_closed, full_closes, results_seen);
    $display("Idle mixes on both sides, plus one %0d-cycle output hold-off with input pending.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/qbpn_pkg.sv
rtl/qbpn_ram.sv
rtl/qbpn_ctrl.sv
rtl/qbpn_dp.sv
rtl/q15_block_peak_normalize.sv
sim/q15_block_peak_normalize_test.sv
